// ----- hdl/bsa_pkg.sv -----
// Shared definitions for the bitmap slot allocator: parameter defaults,
// bitmap chunking constants and the action and status codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bsa_pkg;

  localparam int unsigned DEF_SLOT_COUNT = 64;
  localparam int unsigned DEF_DATA_WIDTH = 32;

  // The occupancy bitmap is scanned one chunk of 2**CHUNK_LG slots per cycle.
  localparam int unsigned CHUNK_LG = 3;
  localparam int unsigned CHUNK_W  = 1 << CHUNK_LG;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_FIND   = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_NONE  = 2'd3
  } status_e;

endpackage

`default_nettype wire

// ----- hdl/bitmap_slot_allocator.sv -----
// Top level of the bitmap slot allocator: slot data memory, occupancy bitmap,
// chunked bitmap scanner and output register. Depends on bsa_pkg.
`timescale 1ns / 1ps
`default_nettype none

// The bitmap slot allocator keeps SLOT_COUNT data words in a synchronous
// memory and tracks which slots are occupied in a bitmap register. An insert
// item writes its word into the slot at the next-free pointer and returns
// that slot; a remove item clears a run of slots; a find item returns the
// first occupied slot at or after a given index together with its word.
// Every item gives exactly one result item, which also carries the number
// of occupied slots after the item. The block works on one item at a time:
// an item that needs no bitmap scan (a refused insert, an insert with no
// slot above it to search, a rejected or empty remove, a find starting at
// or beyond the capacity in use, and the unused action code) goes straight
// from acceptance to its result. Items that scan visit one 8-slot bitmap
// chunk per cycle, at most SLOT_COUNT/8 rounded up (8 for 64 slots), and a
// find that hits then reads its word from the memory before its result.
// The result sits in an output register, so the block takes its next item
// while the previous result waits to be taken; it holds off only if a
// second result is ready before the first is gone.
// The capacity register is written through its own valid/ready port, which
// is always ready; write it only while the block is idle. Values above
// SLOT_COUNT act as SLOT_COUNT, and zero means no slot is in use.

module bitmap_slot_allocator #(
  parameter int unsigned SLOT_COUNT = bsa_pkg::DEF_SLOT_COUNT,
  parameter int unsigned DATA_WIDTH = bsa_pkg::DEF_DATA_WIDTH,
  localparam int unsigned IdxW = $clog2(SLOT_COUNT),
  localparam int unsigned CntW = $clog2(SLOT_COUNT + 1)
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,

  input  wire                   cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire  [CntW-1:0]       cfg_data_i,

  input  wire                   in_valid_i,
  output logic                  in_stall_o,
  input  wire  [1:0]            action_i,
  input  wire  [IdxW-1:0]       slot_index_i,
  input  wire  [CntW-1:0]       slot_count_i,
  input  wire  [DATA_WIDTH-1:0] write_data_i,

  output logic                  out_valid_o,
  input  wire                   out_stall_i,
  output bsa_pkg::status_e      status_o,
  output logic [IdxW-1:0]       result_index_o,
  output logic [DATA_WIDTH-1:0] read_data_o,
  output logic [CntW-1:0]       occupied_count_o
);

  import bsa_pkg::*;

  localparam int unsigned NumChunks = (SLOT_COUNT + CHUNK_W - 1) / CHUNK_W;
  localparam int unsigned ChkW      = (NumChunks > 1) ? $clog2(NumChunks) : 1;
  localparam int unsigned PosW      = ChkW + CHUNK_LG;
  localparam int unsigned MapW      = NumChunks * CHUNK_W;
  localparam int unsigned SumW      = CntW + 1;
  localparam int unsigned CmpW      = PosW + CntW;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_READ = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  function automatic logic [ChkW-1:0] chunk_of(input logic [CntW-1:0] pos);
    return ChkW'(pos >> CHUNK_LG);
  endfunction

  function automatic logic [CHUNK_LG-1:0] lowest_set(input logic [CHUNK_W-1:0] v);
    logic [CHUNK_LG-1:0] r;
    r = '0;
    for (int j = CHUNK_W - 1; j >= 0; j--) begin
      if (v[j]) begin
        r = CHUNK_LG'(j);
      end
    end
    return r;
  endfunction

  function automatic logic [CHUNK_LG:0] ones_in(input logic [CHUNK_W-1:0] v);
    logic [CHUNK_LG:0] n;
    n = '0;
    for (int j = 0; j < CHUNK_W; j++) begin
      n = n + (CHUNK_LG + 1)'(v[j]);
    end
    return n;
  endfunction

  // Control state.
  state_e          state_q, state_d;
  logic [MapW-1:0] map_q, map_d;
  logic [IdxW-1:0] next_free_q, next_free_d;
  logic [CntW-1:0] total_q, total_d;
  logic [CntW-1:0] cap_q;
  logic            out_valid_q, out_valid_d;

  // Item under work and scan window.
  action_e         op_act_q, op_act_d;
  logic [CntW-1:0] lo_q, lo_d;
  logic [CntW-1:0] hi_q, hi_d;
  logic [ChkW-1:0] scan_chk_q, scan_chk_d;
  logic [ChkW-1:0] last_chk_q, last_chk_d;

  // Pending result and output register.
  status_e               res_status_q, res_status_d;
  logic [IdxW-1:0]       res_index_q, res_index_d;
  logic [DATA_WIDTH-1:0] res_data_q, res_data_d;
  status_e               out_status_q;
  logic [IdxW-1:0]       out_index_q;
  logic [DATA_WIDTH-1:0] out_data_q;
  logic [CntW-1:0]       out_count_q;

  // Slot memory.
  logic [DATA_WIDTH-1:0] mem_q [SLOT_COUNT];
  logic [DATA_WIDTH-1:0] rd_data_q;
  logic                  mem_we;
  logic                  rd_en;
  logic [IdxW-1:0]       rd_addr;

  logic [CntW-1:0]     cap_eff;
  logic                accept;
  logic                out_load;
  logic                ins_fail;
  logic [CntW-1:0]     ins_lo;
  logic [SumW-1:0]     rm_end;
  logic [PosW-1:0]     chk_base;
  logic [CHUNK_W-1:0]  chunk_bits;
  logic [CHUNK_W-1:0]  in_rng;
  logic [CHUNK_W-1:0]  target;
  logic                hit;
  logic [PosW-1:0]     hit_pos;
  logic                at_last;

  assign cap_eff = (cap_q > CntW'(SLOT_COUNT)) ? CntW'(SLOT_COUNT) : cap_q;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign out_load    = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  // An insert is refused when the pointer slot is past the capacity, already
  // taken, or the store already holds as many items as the capacity allows.
  assign ins_fail = (CntW'(next_free_q) >= cap_eff) || map_q[next_free_q] ||
                    (total_q >= cap_eff);
  assign ins_lo   = CntW'(next_free_q) + CntW'(1);
  assign rm_end   = SumW'(slot_index_i) + SumW'(slot_count_i);

  // The scanner looks at one bitmap chunk per cycle and masks it to the
  // window [lo, hi) of the item under work.
  assign chk_base   = {scan_chk_q, {CHUNK_LG{1'b0}}};
  assign chunk_bits = map_q[chk_base +: CHUNK_W];

  always_comb begin
    for (int j = 0; j < CHUNK_W; j++) begin
      in_rng[j] = (CmpW'({scan_chk_q, CHUNK_LG'(j)}) >= CmpW'(lo_q)) &&
                  (CmpW'({scan_chk_q, CHUNK_LG'(j)}) <  CmpW'(hi_q));
    end
  end

  // Insert looks for a free slot; find and remove look at occupied ones.
  assign target  = (op_act_q == ACT_INSERT) ? (~chunk_bits & in_rng)
                                            : (chunk_bits & in_rng);
  assign hit     = |target;
  assign hit_pos = {scan_chk_q, lowest_set(target)};
  assign at_last = (scan_chk_q == last_chk_q);

  always_comb begin
    state_d      = state_q;
    map_d        = map_q;
    next_free_d  = next_free_q;
    total_d      = total_q;
    op_act_d     = op_act_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    scan_chk_d   = scan_chk_q;
    last_chk_d   = last_chk_q;
    res_status_d = res_status_q;
    res_index_d  = res_index_q;
    res_data_d   = res_data_q;
    mem_we       = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = hit_pos[IdxW-1:0];

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_act_d     = action_e'(action_i);
          res_status_d = ST_OK;
          res_index_d  = '0;
          res_data_d   = '0;
          state_d      = S_DONE;
          case (action_e'(action_i))
            ACT_INSERT: begin
              if (ins_fail) begin
                res_status_d = ST_FULL;
              end else begin
                mem_we              = 1'b1;
                map_d[next_free_q]  = 1'b1;
                total_d             = total_q + CntW'(1);
                res_index_d         = next_free_q;
                res_data_d          = write_data_i;
                // With no slot above, the pointer stays on the slot taken.
                if (ins_lo < cap_eff) begin
                  lo_d       = ins_lo;
                  hi_d       = cap_eff;
                  scan_chk_d = chunk_of(ins_lo);
                  last_chk_d = chunk_of(cap_eff - CntW'(1));
                  state_d    = S_SCAN;
                end
              end
            end
            ACT_REMOVE: begin
              if (rm_end > SumW'(cap_eff)) begin
                res_status_d = ST_RANGE;
              end else begin
                if (slot_index_i < next_free_q) begin
                  next_free_d = slot_index_i;
                end
                if (slot_count_i != '0) begin
                  lo_d       = CntW'(slot_index_i);
                  hi_d       = rm_end[CntW-1:0];
                  scan_chk_d = chunk_of(CntW'(slot_index_i));
                  last_chk_d = chunk_of(rm_end[CntW-1:0] - CntW'(1));
                  state_d    = S_SCAN;
                end
              end
            end
            ACT_FIND: begin
              if (CntW'(slot_index_i) >= cap_eff) begin
                res_status_d = ST_NONE;
              end else begin
                lo_d       = CntW'(slot_index_i);
                hi_d       = cap_eff;
                scan_chk_d = chunk_of(CntW'(slot_index_i));
                last_chk_d = chunk_of(cap_eff - CntW'(1));
                state_d    = S_SCAN;
              end
            end
            default: begin
              res_status_d = ST_OK;
            end
          endcase
        end
      end

      S_SCAN: begin
        case (op_act_q)
          ACT_INSERT: begin
            if (hit) begin
              next_free_d = hit_pos[IdxW-1:0];
              state_d     = S_DONE;
            end else if (at_last) begin
              state_d = S_DONE;
            end else begin
              scan_chk_d = scan_chk_q + ChkW'(1);
            end
          end
          ACT_REMOVE: begin
            map_d[chk_base +: CHUNK_W] = chunk_bits & ~in_rng;
            total_d = total_q - CntW'(ones_in(target));
            if (at_last) begin
              state_d = S_DONE;
            end else begin
              scan_chk_d = scan_chk_q + ChkW'(1);
            end
          end
          ACT_FIND: begin
            if (hit) begin
              rd_en        = 1'b1;
              res_status_d = ST_OK;
              res_index_d  = hit_pos[IdxW-1:0];
              state_d      = S_READ;
            end else if (at_last) begin
              res_status_d = ST_NONE;
              state_d      = S_DONE;
            end else begin
              scan_chk_d = scan_chk_q + ChkW'(1);
            end
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end

      S_READ: begin
        res_data_d = rd_data_q;
        state_d    = S_DONE;
      end

      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      map_q       <= '0;
      next_free_q <= '0;
      total_q     <= '0;
      cap_q       <= CntW'(SLOT_COUNT);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      map_q       <= map_d;
      next_free_q <= next_free_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_act_q     <= op_act_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    scan_chk_q   <= scan_chk_d;
    last_chk_q   <= last_chk_d;
    res_status_q <= res_status_d;
    res_index_q  <= res_index_d;
    res_data_q   <= res_data_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_index_q  <= res_index_q;
      out_data_q   <= res_data_q;
      out_count_q  <= total_q;
    end
  end

  // Slot memory: one write port for inserts, one registered read port for finds.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[next_free_q] <= write_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign result_index_o   = out_index_q;
  assign read_data_o      = out_data_q;
  assign occupied_count_o = out_count_q;

endmodule

`default_nettype wire
